>>> hw/rtl/pqe_pkg.sv
// Shared types and constants for the positional queue engine.
`timescale 1ns / 1ps

package pqe_pkg;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         span;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic                     found;
        logic [POS_W-1:0]         where;
        logic signed [DATA_W-1:0] removed_value;
        logic [POS_W-1:0]         count;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic place;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep;
        logic last;
        logic place;
    } t_sts;

endpackage

>>> hw/rtl/pqe_datapath.sv
// Datapath: entry memory, count, sweep address logic and result registers.
`timescale 1ns / 1ps

module pqe_datapath #(
    parameter int ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  pqe_pkg::t_cmd i_cmd,
    input  pqe_pkg::t_in  i_in,
    output pqe_pkg::t_sts o_sts,
    output pqe_pkg::t_out o_out
);
    import pqe_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [DATA_W-1:0] r_mem [ENTRIES];

    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_left;
    logic              r_rd_vld;
    logic              r_place;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_val;
    logic [AW-1:0]     r_src;
    logic [AW-1:0]     r_n;
    logic [AW-1:0]     r_at;
    logic [AW-1:0]     r_rd_addr;
    logic [DATA_W-1:0] r_rd_data;
    logic [ST_W-1:0]   r_status;
    logic              r_found;
    logic [POS_W-1:0]  r_where;
    logic [DATA_W-1:0] r_removed;
    t_out              r_out;

    logic [POS_W-1:0]  pos_eff;
    logic [XW-1:0]     pos_x, cnt_x, at_x, room_x, span_x, n_x;
    logic              full, empty;
    logic [ST_W-1:0]   d_status;
    logic [CW-1:0]     d_left;
    logic [AW-1:0]     d_src, d_n;
    logic              d_place;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    // Decode of the incoming item against the current fill level.
    always_comb begin
        pos_eff  = (i_in.position == '0) ? POS_W'(1) : i_in.position;
        pos_x    = XW'(pos_eff);
        cnt_x    = XW'(r_count);
        at_x     = pos_x - XW'(1);
        room_x   = cnt_x - at_x;
        span_x   = XW'(i_in.span);
        n_x      = (span_x < room_x) ? span_x : room_x;
        full     = (r_count == CW'(ENTRIES));
        empty    = (r_count == '0);
        d_status = ST_OK;
        n_count  = r_count;
        d_left   = '0;
        d_src    = '0;
        d_n      = AW'(1);
        d_place  = 1'b0;
        case (i_in.op)
            OP_PUSH: begin
                if (full) begin
                    d_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_left  = r_count;
                    n_count = r_count - CW'(1);
                end
            end
            OP_INSERT: begin
                if (full) begin
                    d_status = ST_FULL;
                end else if (pos_x > cnt_x + XW'(1)) begin
                    d_status = ST_BADPOS;
                end else begin
                    // Move the tail up one place, last entry first.
                    d_left  = CW'(room_x);
                    d_src   = AW'(r_count - CW'(1));
                    d_place = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_DELETE: begin
                if (pos_x > cnt_x) begin
                    d_status = ST_BADPOS;
                end else begin
                    d_n     = AW'(n_x);
                    d_src   = AW'(at_x + n_x);
                    d_left  = CW'(room_x - n_x);
                    n_count = r_count - CW'(n_x);
                end
            end
            OP_SEARCH: begin
                d_left = r_count;
            end
            default: begin
            end
        endcase
    end

    // One write port: a push at accept, the final placement of an insert,
    // or the move of the word read in the previous cycle.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_addr;
        wr_data = r_rd_data;
        if (i_cmd.accept && i_in.op == OP_PUSH && !full) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_count);
            wr_data = i_in.value;
        end else if (i_cmd.place) begin
            wr_en   = 1'b1;
            wr_addr = r_at;
            wr_data = r_val;
        end else if (r_rd_vld) begin
            case (r_op)
                OP_INSERT: begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_addr + AW'(1);
                end
                OP_POP: begin
                    // The front word leaves; every later word moves down.
                    wr_en   = (r_rd_addr != '0);
                    wr_addr = r_rd_addr - r_n;
                end
                OP_DELETE: begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_addr - r_n;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.step) begin
            r_rd_data <= r_mem[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
            r_place  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
            if (i_cmd.accept) begin
                r_count <= n_count;
                r_left  <= d_left;
                r_place <= d_place;
            end else if (i_cmd.step) begin
                r_left <= r_left - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_in.op;
            r_val     <= i_in.value;
            r_src     <= d_src;
            r_n       <= d_n;
            r_at      <= AW'(at_x);
            r_status  <= d_status;
            r_found   <= 1'b0;
            r_where   <= '0;
            r_removed <= '0;
        end else begin
            if (i_cmd.step) begin
                r_rd_addr <= r_src;
                r_src     <= (r_op == OP_INSERT) ? r_src - AW'(1) : r_src + AW'(1);
            end
            if (r_rd_vld && r_op == OP_SEARCH && !r_found && r_rd_data == r_val) begin
                r_found <= 1'b1;
                r_where <= POS_W'({1'b0, r_rd_addr} + (AW + 1)'(1));
            end
            if (r_rd_vld && r_op == OP_POP && r_rd_addr == '0) begin
                r_removed <= r_rd_data;
            end
        end
        if (i_cmd.load_out) begin
            r_out.status        <= r_status;
            r_out.found         <= r_found;
            r_out.where         <= r_where;
            r_out.removed_value <= r_removed;
            r_out.count         <= POS_W'(r_count);
        end
    end

    assign o_sts.sweep = (r_left != '0);
    assign o_sts.last  = (r_left == CW'(1));
    assign o_sts.place = r_place;
    assign o_out       = r_out;

endmodule

>>> hw/rtl/pqe_ctrl.sv
// Controller state machine: sequences accept, sweep, placement and result transfer.
`timescale 1ns / 1ps

module pqe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  pqe_pkg::t_sts i_sts,
    output pqe_pkg::t_cmd o_cmd
);
    import pqe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.sweep) begin
                    n_state = S_SWEEP;
                end else if (i_sts.place) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The word read in the last sweep cycle is written back here.
                n_state = i_sts.place ? S_PLACE : S_DONE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/positional_queue_engine_top.sv
// Top level of the positional queue engine.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in  (op, position, span, value)
//  out     | output    | o_out_valid/i_out_ready | o_out (status, found, where,
//          |           |                         |        removed_value, count)
//
// One item at a time. Push, failures and unused codes need no sweep; pop, delete and
// search sweep L words, and insert sweeps L words and then places the new one, where L (up to ENTRIES)
// words are swept one per cycle through the memory's single read port. With L zero the
// sweep and its drain step drop out, and an insert at the back only places its word.
// Reset is synchronous and active low; it empties the queue. The memory needs no
// clearing pass. A result waits in the output register while the next item is worked
// on; that item then holds its result until the register frees.
`timescale 1ns / 1ps

module positional_queue_engine_top #(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pqe_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pqe_pkg::t_out o_out
);
    import pqe_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pqe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pqe_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule

>>> hw/rtl/pqe_checker.sv
// Port-level checker for the positional queue engine and its bind statement.
`timescale 1ns / 1ps

module pqe_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input pqe_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input pqe_pkg::t_out o_out
);
    import pqe_pkg::*;

    // A result waiting for transfer must stay offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    // An empty report can only come from a queue that holds nothing.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_EMPTY |-> o_out.count == '0)
        else $error("empty status with nonzero count");

    // Without a match the reported position is zero.
    a_where_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.found |-> o_out.where == '0)
        else $error("position reported without a match");

    // Only a successful operation returns a removed word or a match.
    a_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.removed_value != '0 || o_out.found) |->
            o_out.status == ST_OK)
        else $error("removed word or match on a failed operation");

    // While the engine works on an item it takes no new one.
    a_no_accept_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready in the cycle after a transfer");

endmodule

bind positional_queue_engine_top pqe_checker u_pqe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

>>> bench/pqe_tb_pkg.sv
// Queue mirror that predicts and checks the results of the positional queue engine.
`timescale 1ns / 1ps

package pqe_tb_pkg;

    import pqe_pkg::*;

    localparam int QUEUE_DEPTH = 64;

    class queue_mirror;

        logic [DATA_W-1:0] held[$];
        t_out              awaited[$];
        int                mismatches;
        int                transfers_in;
        int                results_seen;
        int                search_hits;
        int                status_tally[4];

        function new();
            mismatches   = 0;
            transfers_in = 0;
            results_seen = 0;
            search_hits  = 0;
            foreach (status_tally[s]) status_tally[s] = 0;
        endfunction

        function int depth();
            return held.size();
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // A word that is currently held, so that searches can hit (zero when the queue is empty).
        function logic [DATA_W-1:0] stored_word();
            if (held.size() == 0) return '0;
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        // Applies one accepted operation to the mirror and queues its result.
        function void note_request(t_in req);
            t_out res;
            int   at;
            int   n;
            int   i;
            res = '0;
            // Position zero addresses the front, the same as position one.
            at = (req.position == '0) ? 0 : int'(req.position) - 1;
            case (req.op)
                OP_PUSH: begin
                    if (held.size() >= QUEUE_DEPTH) res.status = ST_FULL;
                    else held.push_back(req.value);
                end
                OP_POP: begin
                    if (held.size() == 0) res.status = ST_EMPTY;
                    else res.removed_value = held.pop_front();
                end
                OP_INSERT: begin
                    // A full store is reported before the position is looked at.
                    if (held.size() >= QUEUE_DEPTH) res.status = ST_FULL;
                    else if (at > held.size()) res.status = ST_BADPOS;
                    else held.insert(at, req.value);
                end
                OP_DELETE: begin
                    if (at >= held.size()) begin
                        res.status = ST_BADPOS;
                    end else begin
                        n = int'(req.span);
                        if (n > held.size() - at) n = held.size() - at;
                        repeat (n) held.delete(at);
                    end
                end
                OP_SEARCH: begin
                    for (i = 0; i < held.size(); i++) begin
                        if (held[i] == req.value) begin
                            res.found = 1'b1;
                            res.where = POS_W'(i + 1);
                            break;
                        end
                    end
                end
                default: ;
            endcase
            res.count = POS_W'(held.size());
            status_tally[res.status]++;
            if (res.found) search_hits++;
            transfers_in++;
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            results_seen++;
            if (awaited.size() == 0) begin
                $display("%0t: result transfer with nothing outstanding, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("where", 32'(want.where), 32'(got.where));
            compare_field("removed_value", want.removed_value, got.removed_value);
            compare_field("count", 32'(want.count), 32'(got.count));
        endfunction

    endclass

endpackage

>>> bench/positional_queue_engine_top_tb.sv
// Self-checking testbench for the positional queue engine top level.
`timescale 1ns / 1ps

module positional_queue_engine_top_tb;

    import pqe_pkg::*;
    import pqe_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1280;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_SEARCH + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    t_in   in_word   = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_out  out_word;
    bit    steady    = 1'b0;
    int    cycles    = 0;

    queue_mirror mirror;

    positional_queue_engine_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     mirror.outstanding());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) mirror.check_result(out_word);
    end

    // Mostly short gaps, a few long ones, none at all during steady stretches.
    function automatic int idle_cycles();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin : result_stall
        int hold;
        forever begin
            @(negedge clk);
            hold = idle_cycles();
            if (hold == 0) begin
                out_ready <= 1'b1;
                if (!steady) repeat ($urandom_range(0, 6)) @(negedge clk);
            end else begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
        end
    end

    function automatic t_in make_req(logic [OP_W-1:0] op, logic [POS_W-1:0] position,
                                     logic [POS_W-1:0] span, logic [DATA_W-1:0] value);
        t_in req;
        req.op       = op;
        req.position = position;
        req.span     = span;
        req.value    = value;
        return req;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int top);
        if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, top));
        return POS_W'($urandom);
    endfunction

    // Small values repeat often, so searches see duplicates and first-match order.
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 30) return DATA_W'(int'($urandom_range(0, 7)) - 4);
        return $urandom;
    endfunction

    // Fill mode leans on push and insert, drain mode on pop and delete.
    function automatic t_in random_req(int mode);
        t_in req;
        int  roll;
        int  fill_share;
        int  held_now;
        held_now     = mirror.depth();
        fill_share   = (mode == 0) ? 80 : (mode == 1) ? 50 : 20;
        req.position = POS_W'($urandom);
        req.span     = POS_W'($urandom);
        req.value    = pick_value();
        roll         = $urandom_range(0, 99);
        if (roll < 3) begin
            req.op = OP_W'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
        end else if (roll < 18) begin
            req.op = OP_SEARCH;
            if ($urandom_range(0, 99) < 60) req.value = mirror.stored_word();
        end else if ($urandom_range(0, 99) < fill_share) begin
            req.op       = $urandom_range(0, 1) ? OP_INSERT : OP_PUSH;
            req.position = pick_position(held_now + 1);
        end else if ($urandom_range(0, 99) < 45) begin
            req.op = OP_POP;
        end else begin
            req.op       = OP_DELETE;
            req.position = pick_position(held_now);
            roll         = $urandom_range(0, 99);
            if (roll < 55) req.span = POS_W'($urandom_range(0, 4));
            else if (roll < 90) req.span = POS_W'($urandom_range(0, 24));
        end
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(t_in req);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word  <= req;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        mirror.note_request(req);
        @(negedge clk);
    endtask

    initial begin : stimulus
        int k;
        mirror = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty queue first: pop, delete, search and an insert past the end.
        send(make_req(OP_POP,    7'd0,   7'd0,   32'h0));
        send(make_req(OP_DELETE, 7'd0,   7'd1,   32'h0));
        send(make_req(OP_SEARCH, 7'd0,   7'd0,   32'h0));
        send(make_req(OP_INSERT, 7'd2,   7'd0,   32'h1));
        send(make_req(OP_INSERT, 7'd0,   7'd0,   32'h7fff_ffff));
        send(make_req(OP_PUSH,   7'd127, 7'd127, 32'h8000_0000));
        send(make_req(OP_PUSH,   7'd0,   7'd0,   32'h0));
        send(make_req(OP_PUSH,   7'd0,   7'd0,   32'hffff_ffff));
        send(make_req(OP_INSERT, 7'd127, 7'd0,   32'h1));
        // Position one past the last entry appends.
        send(make_req(OP_INSERT, 7'd5,   7'd0,   32'h5555_5555));
        send(make_req(OP_INSERT, 7'd1,   7'd0,   32'haaaa_aaaa));
        send(make_req(OP_SEARCH, 7'd0,   7'd0,   32'hffff_ffff));
        send(make_req(OP_SEARCH, 7'd0,   7'd0,   32'h1234_5678));
        send(make_req(OP_DELETE, 7'd2,   7'd0,   32'h0));
        send(make_req(OP_SPARE_LO, 7'd127, 7'd127, 32'hffff_ffff));
        send(make_req(OP_SPARE_LO + 3'd1, 7'd1, 7'd1, 32'h0));
        send(make_req(OP_SPARE_HI, 7'd64, 7'd64, 32'h8000_0000));
        send(make_req(OP_DELETE, 7'd127, 7'd127, 32'h0));
        // A run longer than what is left gets clipped at the back.
        send(make_req(OP_DELETE, 7'd3,   7'd127, 32'h0));
        send(make_req(OP_POP,    7'd0,   7'd0,   32'h0));
        send(make_req(OP_SEARCH, 7'd0,   7'd0,   32'h7fff_ffff));
        send(make_req(OP_DELETE, 7'd0,   7'd64,  32'h0));
        send(make_req(OP_POP,    7'd0,   7'd0,   32'h0));

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            steady = (k % 250) >= 200;
            send(random_req((k / 160) % 3));
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (mirror.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d operations transferred, %0d results compared, %0d mismatches.",
                 mirror.transfers_in, mirror.results_seen, mirror.mismatches);
        $display("Outcomes: %0d ok, %0d pops on empty, %0d full, %0d bad positions, %0d search hits.",
                 mirror.status_tally[ST_OK], mirror.status_tally[ST_EMPTY],
                 mirror.status_tally[ST_FULL], mirror.status_tally[ST_BADPOS],
                 mirror.search_hits);
        if (mirror.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pqe_pkg.sv
hw/rtl/pqe_datapath.sv
hw/rtl/pqe_ctrl.sv
hw/rtl/positional_queue_engine_top.sv
hw/rtl/pqe_checker.sv
bench/pqe_tb_pkg.sv
bench/positional_queue_engine_top_tb.sv
